/* hdl/stbs_pkg.sv */
`timescale 1ns / 1ps

package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 11;
   localparam int DATA_W      = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [IDX_W-1:0]         write_index;
      logic signed [DATA_W-1:0] write_value;
      logic signed [DATA_W-1:0] search_key;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

   // Search window [lo, hi) and the probe position inside it
   typedef struct packed {
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
      logic [IDX_W-1:0] mid;
   } win_type;

   typedef struct packed {
      logic    eq;
      logic    done;
      win_type nxt;
   } step_type;

   // Floor midpoint of the inclusive range [lo, hi-1]; valid for lo < hi
   function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} - (CNT_W+1)'(1);
      return sum[IDX_W:1];
   endfunction

endpackage

/* hdl/stbs_step.sv */
`timescale 1ns / 1ps

module stbs_step (
   input  stbs_pkg::win_type         win,
   input  logic signed [31:0]        probe,
   input  logic signed [31:0]        key,
   output stbs_pkg::step_type        step
);
   import stbs_pkg::*;

   logic             gt;
   logic [CNT_W-1:0] mid_w;
   logic [CNT_W-1:0] lo_in;
   logic [CNT_W-1:0] hi_in;

   assign gt    = probe > key;
   assign mid_w = {1'b0, win.mid};
   assign lo_in = gt ? win.lo : mid_w + CNT_W'(1);
   assign hi_in = gt ? mid_w : win.hi;

   always_comb begin
      step.eq      = (probe == key);
      step.done    = step.eq || (lo_in >= hi_in);
      step.nxt.lo  = lo_in;
      step.nxt.hi  = hi_in;
      step.nxt.mid = mid_of(lo_in, hi_in);
   end

endmodule

/* hdl/stbs_seq.sv */
`timescale 1ns / 1ps

module stbs_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [10:0]               count,
   input  logic                      req_valid,
   input  stbs_pkg::req_type         req,
   output logic                      req_stall,
   output logic                      rsp_valid,
   output stbs_pkg::rsp_type         rsp,
   input  logic                      rsp_stall
);
   import stbs_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PROBE = 1'b1;

   logic state_ff, state_in;
   win_type win_ff, win_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;

   logic     accept;
   logic     wr_en;
   step_type step;

   stbs_step u_step (
      .win   (win_ff),
      .probe (rd_data_ff),
      .key   (key_ff),
      .step  (step)
   );

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req.opcode == OP_WRITE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = win_ff.mid;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req.opcode == OP_LOOKUP) begin
               key_in = req.search_key;
               cnt_in = count;
               if (count == '0) begin
                  // empty table: answer at once
                  rsp_in.found       = 1'b0;
                  rsp_in.match_index = '0;
                  rsp_valid_in       = 1'b1;
               end else begin
                  win_in.lo  = '0;
                  win_in.hi  = count;
                  win_in.mid = mid_of('0, count);
                  rd_en      = 1'b1;
                  rd_addr    = win_in.mid;
                  state_in   = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (step.done) begin
               rsp_in.found       = step.eq;
               rsp_in.match_index = step.eq ? win_ff.mid : '0;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               // narrow and fetch the next midpoint
               win_in  = step.nxt;
               rd_en   = 1'b1;
               rd_addr = step.nxt.mid;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req.write_index] <= req.write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   a_window_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (win_ff.lo < win_ff.hi))
      else $error("probe with empty window");

   a_mid_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |->
         ({1'b0, win_ff.mid} >= win_ff.lo) && ({1'b0, win_ff.mid} < win_ff.hi))
      else $error("probe index outside window");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> ({1'b0, rsp_ff.match_index} < cnt_ff))
      else $error("match index beyond searched entries");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.match_index == '0))
      else $error("miss with nonzero index");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> !wr_en)
      else $error("table write during search");

endmodule

/* hdl/sorted_table_binary_search.sv */
`timescale 1ns / 1ps
// Channel   Ports                              Item
// -------   --------------------------------   ---------------------------
// request   req_valid, req_stall, req          table write or key lookup
// response  rsp_valid, rsp_stall, rsp          found flag and match index
// csr       csr_write_enable, csr_write_data   entries_in_use
//
// A write lands in the table at its accepting edge. A lookup's result follows
// P probes (none for an empty table), P being at most 11 for 1024 entries:
// one registered table read and one compare per probe in the shared step unit.
// The request side stalls until the lookup's result is registered.
// Reset clears the sequencer, the result valid flag and entries_in_use, not the table.
// A stalled result holds and stalls the request side.

module sorted_table_binary_search (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  stbs_pkg::req_type     req,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output stbs_pkg::rsp_type     rsp,
   input  logic                  rsp_stall,
   input  logic                  csr_write_enable,
   input  logic [10:0]           csr_write_data
);
   import stbs_pkg::*;

   logic [CNT_W-1:0] in_use_ff, in_use_in;
   logic [CNT_W-1:0] count;

   assign in_use_in = csr_write_enable ? csr_write_data : in_use_ff;

   // clamp to the table size
   assign count = (in_use_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   stbs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .count     (count),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import stbs_pkg::*;

   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_LOOKUPS = 200;
   localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;

   logic             clock;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   req_type          req              = '0;
   logic             req_stall;
   logic             rsp_valid;
   rsp_type          rsp;
   logic             rsp_stall        = 1'b0;
   logic             csr_write_enable = 1'b0;
   logic [CNT_W-1:0] csr_write_data   = '0;

   sorted_table_binary_search dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req              (req),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // table as the block holds it, and as it will be once the queued writes land
   logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
   logic signed [DATA_W-1:0] staged_table [TABLE_DEPTH];
   int unsigned              shadow_count = 0;

   // planned contents; an entry is written only once a search will probe it
   logic signed [DATA_W-1:0] plan_table [TABLE_DEPTH];
   bit                       fresh [TABLE_DEPTH];

   req_type pending_items [$];
   rsp_type expected_lookups [$];

   bit sender_idle   = 1'b0;
   bit receiver_idle = 1'b0;
   bit hold_request  = 1'b0;

   int gap_left        = 0;
   int stall_left      = 0;
   int hold_count      = 0;
   int writes_done     = 0;
   int lookups_checked = 0;
   int hits_seen       = 0;
   int mismatch_count  = 0;
   int csr_writes      = 0;
   int cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type search_table(input logic signed [DATA_W-1:0] key);
      rsp_type hit;
      int      lo;
      int      hi;
      int      mid;
      hit = '0;
      lo  = 0;
      hi  = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count)) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_table[mid] == key) begin
            hit.found       = 1'b1;
            hit.match_index = mid[IDX_W-1:0];
            lo              = hi + 1;
         end else if (shadow_table[mid] > key) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return hit;
   endfunction

   function automatic void queue_write(input int idx, input logic signed [DATA_W-1:0] value);
      req_type item;
      item.opcode      = OP_WRITE;
      item.write_index = idx[IDX_W-1:0];
      item.write_value = value;
      item.search_key  = $urandom;
      pending_items    = {pending_items, item};
      staged_table[idx] = value;
      fresh[idx]        = 1'b1;
   endfunction

   function automatic void queue_lookup(input logic signed [DATA_W-1:0] key);
      req_type item;
      item.opcode      = OP_LOOKUP;
      item.write_index = IDX_W'($urandom);
      item.write_value = $urandom;
      item.search_key  = key;
      pending_items    = {pending_items, item};
   endfunction

   // write each entry on the probe path that is not current yet, then look up
   function automatic void queue_search(input logic signed [DATA_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count)) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (!fresh[mid])
            queue_write(mid, plan_table[mid]);
         if (staged_table[mid] == key)
            lo = hi + 1;
         else if (staged_table[mid] > key)
            hi = mid - 1;
         else
            lo = mid + 1;
      end
      queue_lookup(key);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_lookups.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only while the block is idle
   task automatic program_entry_count(input int n);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= CNT_W'(n);
      shadow_count      = n;
      csr_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // driver: predict on acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req.opcode == OP_WRITE) begin
               shadow_table[req.write_index] = req.write_value;
               writes_done++;
            end else begin
               expected_lookups = {expected_lookups, search_table(req.search_key)};
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sender_idle && pending_items.size() != 0 &&
                         $urandom_range(0, 5) == 0) begin
               gap_left   = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req       <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold to fill the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && hold_count < LONG_HOLD) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("unexpected item found=%0b index=%0d",
                                      rsp.found, rsp.match_index));
         end else begin
            want = expected_lookups.pop_front();
            lookups_checked++;
            if (rsp.found !== want.found || rsp.match_index !== want.match_index) begin
               report_mismatch($sformatf("expected found=%0b index=%0d, got found=%0b index=%0d",
                                         want.found, want.match_index,
                                         rsp.found, rsp.match_index));
            end else if (want.found) begin
               hits_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_lookups.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int                       n;
      int                       n_eff;
      int                       idx;
      int                       step_max;
      int                       pick;
      int                       phase_items;
      int                       lookups_planned;
      int                       i;
      int                       j;
      longint                   v;
      logic signed [DATA_W-1:0] key;
      bit                       first_phase;
      bit                       tail;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table
      program_entry_count(0);
      queue_search(MIN_VAL);
      queue_search(MAX_VAL);
      queue_search('0);

      // sorted plan: extremes at both ends, a run of equal entries at 100..103
      for (i = 0; i < TABLE_DEPTH; i++) begin
         v = longint'(MIN_VAL) + longint'(i) * 64'd4194304;
         if (i >= 101 && i <= 103)
            v = longint'(MIN_VAL) + 64'd100 * 64'd4194304;
         if (i == TABLE_DEPTH - 1)
            v = longint'(MAX_VAL);
         plan_table[i] = v[DATA_W-1:0];
      end

      program_entry_count(TABLE_DEPTH);
      queue_search(MIN_VAL);
      queue_search(MAX_VAL);
      queue_search(plan_table[100]);
      queue_search(plan_table[511]);
      queue_search(plan_table[512]);
      queue_search(plan_table[1] + 1);
      queue_search(MIN_VAL + 1);
      queue_search(MAX_VAL - 1);

      // count above the depth saturates
      program_entry_count(2047);
      queue_search(MAX_VAL);
      queue_search(plan_table[1000]);

      program_entry_count(1);
      queue_search(MIN_VAL);
      queue_search(plan_table[1]);

      // break the order at the first probe and search anyway
      program_entry_count(16);
      queue_write(7, MAX_VAL);
      queue_search(plan_table[3]);
      queue_search(plan_table[12]);
      queue_search(MAX_VAL);

      first_phase     = 1'b1;
      lookups_planned = 0;
      while (lookups_planned < RANDOM_LOOKUPS) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)       n = 0;
         else if (pick < 35) n = $urandom_range(1, 8);
         else if (pick < 75) n = $urandom_range(9, 64);
         else if (pick < 90) n = $urandom_range(65, 300);
         else if (pick < 96) n = TABLE_DEPTH;
         else                n = $urandom_range(TABLE_DEPTH + 1, 2047);
         program_entry_count(n);
         n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;

         tail          = lookups_planned >= RANDOM_LOOKUPS - 50;
         sender_idle   = !tail && $urandom_range(0, 3) != 0;
         receiver_idle = !tail && $urandom_range(0, 3) != 0;

         // fresh sorted prefix, dense steps give duplicates
         if (n_eff > 0) begin
            step_max = ($urandom_range(0, 1) == 1) ? 3 : (1 << $urandom_range(4, 21));
            v = ($urandom_range(0, 9) == 0) ? longint'(MIN_VAL) : longint'($signed($urandom));
            if (v + longint'(n_eff) * step_max > longint'(MAX_VAL))
               v = longint'(MAX_VAL) - longint'(n_eff) * step_max;
            for (i = 0; i < n_eff; i++) begin
               plan_table[i] = v[DATA_W-1:0];
               v += $urandom_range(0, step_max);
            end
            for (i = 0; i < TABLE_DEPTH; i++)
               fresh[i] = 1'b0;
         end

         phase_items = first_phase ? 60 : $urandom_range(15, 50);
         for (j = 0; j < phase_items; j++) begin
            idx  = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else begin
               if (pick < 60)
                  key = plan_table[idx];
               else if (pick < 80)
                  key = plan_table[idx] + (($urandom_range(0, 1) == 1) ? 1 : -1);
               else if (pick < 92)
                  key = $urandom;
               else
                  key = ($urandom_range(0, 1) == 1) ? MIN_VAL : MAX_VAL;
               queue_search(key);
               lookups_planned++;
            end
         end

         if (first_phase) begin
            hold_request = 1'b1;
            first_phase  = 1'b0;
         end
      end

      wait_until_drained();
      $display("Covered %0d table writes and %0d lookups (%0d hits) across %0d entry counts.",
               writes_done, lookups_checked, hits_seen, csr_writes);
      $display("Counts ranged from empty through full and oversized, with a %0d-cycle result hold.",
               LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
